[rtl/core/fsvs_pkg.sv]
`default_nettype none
package fsvs_pkg;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] OP_LOAD_COS = 2'd0;
  localparam logic [1:0] OP_LOAD_SIN = 2'd1;
  localparam logic [1:0] OP_EVAL     = 2'd2;

  // Register index of term_count on the configuration port.
  localparam logic REG_TERM_COUNT = 1'b0;

  localparam int unsigned COEF_W  = 32;
  localparam int unsigned TRIG_W  = 16;
  localparam int unsigned VALUE_W = 40;
  localparam int unsigned SLOPE_W = 44;
  localparam int unsigned ACC_W   = 64;

  // pi/2 in Q30.
  localparam longint unsigned PIHALF_Q30 = 64'd1686629713;

  // Quarter-wave sine of step j out of 2^(table_bits-2), Q15, saturated.
  // Evaluated at elaboration only, to fill the constant table.
  function automatic logic [15:0] quarter_sine(input longint unsigned j,
                                               input int unsigned table_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned r;
    x    = (j * PIHALF_Q30) >> (table_bits - 2);
    x2   = (x * x) >> 30;
    pos  = x;
    neg  = 64'd0;
    term = ((x * x2) >> 30) / 6;
    neg  = neg + term;
    term = ((term * x2) >> 30) / 20;
    pos  = pos + term;
    term = ((term * x2) >> 30) / 42;
    neg  = neg + term;
    term = ((term * x2) >> 30) / 72;
    pos  = pos + term;
    term = ((term * x2) >> 30) / 110;
    neg  = neg + term;
    term = ((term * x2) >> 30) / 156;
    pos  = pos + term;
    r = (pos > neg) ? (pos - neg) : 64'd0;
    r = (r + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

[rtl/core/fsvs_ram.sv]
`default_nettype none
module fsvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/fourier_series_value_and_slope.sv]
`default_nettype none
// Fourier series value and slope evaluator.
// A load beat is taken while idle and the block stays idle. An evaluate beat with n > 0
// terms feeds one coefficient per cycle (cosine, then sine, for each term) into a single
// multiplier pair; with no terms it feeds none. No further beat is taken until its result
// has been presented at the output, so a result still waiting there holds off the next beat.
// Reset clears term_count, the output valid and the per-entry valid bits.
module fourier_series_value_and_slope #(
  parameter int MAX_TERMS  = 16,
  parameter int PHASE_BITS = 16,
  parameter int TABLE_BITS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,  // term_index[3:0], coefficient[35:4], angle_phase[51:36]
  input  wire logic [1:0]  s_tuser,  // opcode[1:0]
  // Output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata   // series_value[39:0], series_slope[83:40]
);

  localparam int AW      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int SW      = AW + 1;
  localparam int KTW     = AW + 17;
  localparam int QUARTER = 1 << (TABLE_BITS - 2);
  localparam int CW      = fsvs_pkg::COEF_W;
  localparam int TW      = fsvs_pkg::TRIG_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // ---------------- configuration ----------------
  logic [4:0] term_count;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= 5'd0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == fsvs_pkg::REG_TERM_COUNT) begin
      term_count <= pwdata[4:0];
    end
  end

  assign prdata = (paddr[2] == fsvs_pkg::REG_TERM_COUNT) ? {27'd0, term_count} : 32'd0;

  // ---------------- input unpack ----------------
  logic [1:0]           in_opcode;
  logic [3:0]           in_term_index;
  logic signed [CW-1:0] in_coefficient;
  logic [15:0]          in_angle_phase;
  logic [AW+3:0]        tidx_ext;
  logic                 tidx_ok;
  logic                 accept;

  assign in_opcode      = s_tuser;
  assign in_term_index  = s_tdata[3:0];
  assign in_coefficient = s_tdata[35:4];
  assign in_angle_phase = s_tdata[51:36];
  assign tidx_ext       = {{AW{1'b0}}, in_term_index};
  assign tidx_ok        = tidx_ext < (AW+4)'(MAX_TERMS);
  assign accept         = s_tvalid && s_tready;

  // ---------------- control ----------------
  logic [1:0]            state;
  logic [SW-1:0]         step;
  logic [SW-1:0]         last_step;
  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] ph;
  logic                  issue;
  logic                  v1, v2, v3;
  logic [SW-1:0]         n_clamped;
  logic [SW:0]           two_n;
  logic                  out_free;
  logic                  emit;

  assign s_tready  = (state == ST_IDLE);
  assign issue     = (state == ST_RUN);
  assign out_free  = !m_tvalid || m_tready;
  assign emit      = (state == ST_DRAIN) && !(v1 || v2 || v3) && out_free;
  assign n_clamped = (32'(term_count) > 32'(MAX_TERMS)) ? SW'(MAX_TERMS) : SW'(term_count);
  assign two_n     = {n_clamped, 1'b0};

  logic we_cos, we_sin;
  assign we_cos = accept && in_opcode == fsvs_pkg::OP_LOAD_COS && tidx_ok;
  assign we_sin = accept && in_opcode == fsvs_pkg::OP_LOAD_SIN && tidx_ok;

  logic [MAX_TERMS-1:0] cos_valid, sin_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_valid <= '0;
      sin_valid <= '0;
    end else begin
      if (we_cos) begin
        cos_valid[tidx_ext[AW-1:0]] <= 1'b1;
      end
      if (we_sin) begin
        sin_valid[tidx_ext[AW-1:0]] <= 1'b1;
      end
    end
  end

  logic signed [fsvs_pkg::ACC_W-1:0] vacc, sacc;
  logic signed [fsvs_pkg::ACC_W-1:0] vround, sround;

  assign vround = (vacc + 64'sd16384) >>> 15;
  assign sround = (sacc + 64'sd16384) >>> 15;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !emit) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && in_opcode == fsvs_pkg::OP_EVAL) begin
            step  <= '0;
            state <= (n_clamped == '0) ? ST_DRAIN : ST_RUN;
          end
        end
        ST_RUN: begin
          step <= step + SW'(1);
          if (step == last_step) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (emit) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_opcode == fsvs_pkg::OP_EVAL) begin
      last_step <= SW'(two_n - (SW+1)'(1));
      phase_r   <= PHASE_BITS'(in_angle_phase);
      ph        <= '0;
    end else if (issue && step[0]) begin
      ph <= ph + phase_r;
    end
    if (emit) begin
      m_tdata <= {4'd0, sround[fsvs_pkg::SLOPE_W-1:0], vround[fsvs_pkg::VALUE_W-1:0]};
    end
  end

  // ---------------- coefficient memories ----------------
  logic [AW-1:0]   k0;
  logic [CW-1:0]   cos_rdata, sin_rdata;

  assign k0 = step[SW-1:1];

  fsvs_ram #(.WIDTH(CW), .DEPTH(MAX_TERMS)) u_cos_ram (
    .clk   (clk),
    .we    (we_cos),
    .waddr (tidx_ext[AW-1:0]),
    .wdata (in_coefficient),
    .raddr (k0),
    .rdata (cos_rdata)
  );

  fsvs_ram #(.WIDTH(CW), .DEPTH(MAX_TERMS)) u_sin_ram (
    .clk   (clk),
    .we    (we_sin),
    .waddr (tidx_ext[AW-1:0]),
    .wdata (in_coefficient),
    .raddr (k0),
    .rdata (sin_rdata)
  );

  // ---------------- sine table ----------------
  logic [15:0] qtab [QUARTER+1];

  for (genvar j = 0; j <= QUARTER; j++) begin : g_qtab
    assign qtab[j] = fsvs_pkg::quarter_sine(64'(j), TABLE_BITS);
  end

  function automatic logic signed [TW-1:0] trig_at(input logic [TABLE_BITS-1:0] idx);
    logic [1:0]              quad;
    logic [TABLE_BITS-2:0]   qj;
    logic [TABLE_BITS-2:0]   qi;
    logic signed [TW-1:0]    v;
    quad = idx[TABLE_BITS-1:TABLE_BITS-2];
    qj   = {1'b0, idx[TABLE_BITS-3:0]};
    qi   = quad[0] ? ((TABLE_BITS-1)'(QUARTER) - qj) : qj;
    v    = $signed(qtab[qi]);
    return quad[1] ? -v : v;
  endfunction

  logic [TABLE_BITS-1:0] tidx;

  if (PHASE_BITS >= TABLE_BITS) begin : g_idx_trunc
    assign tidx = ph[PHASE_BITS-1 -: TABLE_BITS];
  end else begin : g_idx_shift
    assign tidx = {ph, {(TABLE_BITS-PHASE_BITS){1'b0}}};
  end

  // ---------------- datapath pipeline ----------------
  // Stage 1: table lookup and RAM read data.
  logic signed [TW-1:0]  sn1, cs1;
  logic [AW-1:0]         k1;
  logic                  sel1, cv1, sv1;
  // Stage 2: chosen coefficient and trig weights.
  logic signed [CW-1:0]  coef2;
  logic signed [TW-1:0]  tv2;
  logic signed [KTW-1:0] ts2;
  logic signed [KTW-1:0] kcs, ksn;
  // Stage 3: products.
  logic signed [CW+TW-1:0]  pv3;
  logic signed [CW+KTW-1:0] ps3;

  assign kcs = $signed({1'b0, k1}) * cs1;
  assign ksn = $signed({1'b0, k1}) * sn1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    sn1  <= trig_at(tidx);
    cs1  <= trig_at(tidx + TABLE_BITS'(QUARTER));
    k1   <= k0;
    sel1 <= step[0];
    cv1  <= cos_valid[k0];
    sv1  <= sin_valid[k0];

    // A cosine coefficient weighs cos into the value and -k*sin into the slope;
    // a sine coefficient weighs sin and +k*cos.
    if (sel1) begin
      coef2 <= sv1 ? $signed(sin_rdata) : '0;
      tv2   <= sn1;
      ts2   <= kcs;
    end else begin
      coef2 <= cv1 ? $signed(cos_rdata) : '0;
      tv2   <= cs1;
      ts2   <= -ksn;
    end

    pv3 <= coef2 * tv2;
    ps3 <= coef2 * ts2;

    if (accept && in_opcode == fsvs_pkg::OP_EVAL) begin
      vacc <= '0;
      sacc <= '0;
    end else if (v3) begin
      vacc <= vacc + fsvs_pkg::ACC_W'(pv3);
      sacc <= sacc + fsvs_pkg::ACC_W'(ps3);
    end
  end

endmodule
`default_nettype wire
